[sv/dqt_pkg.sv]
// ----------------------------------------------------------------------------
// dqt_pkg
// Shared types and constants of the depth quad triangulator: field widths,
// register indexes, corner and edge tables, and the queue entry format.
// ----------------------------------------------------------------------------
package dqt_pkg;

   localparam int DEPTH_W     = 16;
   localparam int COORD_W     = 12;
   localparam int CSR_DIM_W   = 13;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RATIO    = 2'd2;

   localparam logic [CSR_DIM_W-1:0]  CSR_DIM_RESET   = 13'd4096;
   localparam logic [CSR_DATA_W-1:0] CSR_RATIO_RESET = 16'd3277;

   // Quad corners: 0 upper left, 1 upper right, 2 lower left, 3 current.
   // A triangle is named by the corner it leaves out.
   localparam logic [1:0] TRI_NO_C0 = 2'd0;
   localparam logic [1:0] TRI_NO_C1 = 2'd1;
   localparam logic [1:0] TRI_NO_C2 = 2'd2;
   localparam logic [1:0] TRI_NO_C3 = 2'd3;

   localparam logic [1:0] TRI_CORNER [4][3] = '{
      '{2'd3, 2'd1, 2'd2},
      '{2'd0, 2'd2, 2'd3},
      '{2'd3, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1}
   };

   // The six corner pairs of a quad.
   localparam int NUM_EDGES = 6;
   localparam logic [2:0] E01 = 3'd0;
   localparam logic [2:0] E02 = 3'd1;
   localparam logic [2:0] E03 = 3'd2;
   localparam logic [2:0] E12 = 3'd3;
   localparam logic [2:0] E13 = 3'd4;
   localparam logic [2:0] E23 = 3'd5;

   localparam logic [1:0] EDGE_A [NUM_EDGES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] EDGE_B [NUM_EDGES] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   localparam logic [2:0] TRI_EDGE [4][3] = '{
      '{E13, E12, E23},
      '{E02, E23, E03},
      '{E13, E01, E03},
      '{E02, E12, E01}
   };

   localparam int QUEUE_DEPTH = 4;

   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [3:0][DEPTH_W-1:0] quad_type;

   typedef struct packed {
      quad_type            d;
      logic [COORD_W-1:0]  x0;
      logic [COORD_W-1:0]  y0;
      logic [1:0]          id_a;
      logic [1:0]          id_b;
      logic                two;
   } tri_job_type;

endpackage

[sv/dqt_ram.sv]
// ----------------------------------------------------------------------------
// dqt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dqt_front.sv]
// ----------------------------------------------------------------------------
// dqt_front
// Pixel intake: raster counters, line store, quad capture, corner
// classification and edge checks. Quads that yield a passing triangle are
// pushed into the job queue.
// ----------------------------------------------------------------------------
module dqt_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dqt_pkg::DEPTH_W-1:0]       req_depth,
   input  logic [$clog2(MAX_WIDTH)-1:0]      col_last,
   input  logic [$clog2(MAX_HEIGHT)-1:0]     row_last,
   input  logic [dqt_pkg::CSR_DATA_W-1:0]    max_ratio,
   input  logic                              q_full,
   output logic                              q_push,
   output dqt_pkg::tri_job_type              q_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DW = dqt_pkg::DEPTH_W;
   localparam int XW = dqt_pkg::COORD_W;
   localparam int NE = dqt_pkg::NUM_EDGES;

   logic                accept;
   logic [CW-1:0]       col_ff, col_in, rd_addr;
   logic [RW-1:0]       row_ff, row_in;
   dqt_pkg::depth_type  left_ff, ul_ff, above;
   logic [CW+XW-1:0]    col_ext;
   logic [RW+XW-1:0]    row_ext;
   logic                has_quad;

   // stage 1: captured quad
   logic                s1_valid_ff;
   dqt_pkg::quad_type   s1_quad_ff;
   logic [XW-1:0]       s1_x0_ff, s1_y0_ff;

   // classification and edge terms on stage 1
   logic [NE-1:0][DW-1:0]   diff_c;
   logic [NE-1:0][2*DW-1:0] prod_c;
   logic [3:0]              nz;
   logic [2:0]              nz_cnt;
   logic                    cls_ok, two_c;
   logic [1:0]              id_a_c, id_b_c;

   // stage 2: edge terms registered
   logic                    s2_valid_ff;
   dqt_pkg::quad_type       s2_quad_ff;
   logic [XW-1:0]           s2_x0_ff, s2_y0_ff;
   logic [1:0]              s2_id_a_ff, s2_id_b_ff;
   logic                    s2_two_ff;
   logic [NE-1:0][DW-1:0]   s2_diff_ff;
   logic [NE-1:0][2*DW-1:0] s2_prod_ff;

   logic [NE-1:0] edge_ok;
   logic          pass_a, pass_b, push_need;
   logic          s1_free, s2_free;

   assign accept = req_valid & req_ready;

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= col_last) begin
            col_in = '0;
            row_in = (row_ff >= row_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // read ahead at the next column so the upper pixel is ready at accept
   assign rd_addr = reset ? '0 : col_in;

   dqt_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_depth),
      .rd_addr (rd_addr),
      .rd_data (above)
   );

   assign has_quad = (col_ff != '0) && (row_ff != '0);
   assign col_ext  = {{XW{1'b0}}, col_ff};
   assign row_ext  = {{XW{1'b0}}, row_ff};

   // edge terms and corner classification
   always_comb begin
      logic [DW-1:0] a, b, mx;
      for (int e = 0; e < NE; e++) begin
         a = s1_quad_ff[dqt_pkg::EDGE_A[e]];
         b = s1_quad_ff[dqt_pkg::EDGE_B[e]];
         mx        = (a > b) ? a : b;
         diff_c[e] = (a > b) ? a - b : b - a;
         prod_c[e] = {{DW{1'b0}}, max_ratio} * {{DW{1'b0}}, mx};
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         nz[i] = s1_quad_ff[i] != '0;
      end
      nz_cnt = 3'($countones(nz));
      cls_ok = 1'b0;
      two_c  = 1'b0;
      id_a_c = dqt_pkg::TRI_NO_C0;
      id_b_c = dqt_pkg::TRI_NO_C0;
      if (nz_cnt == 3'd4) begin
         cls_ok = 1'b1;
         two_c  = 1'b1;
         if (diff_c[dqt_pkg::E03] > diff_c[dqt_pkg::E12]) begin
            id_a_c = dqt_pkg::TRI_NO_C0;
            id_b_c = dqt_pkg::TRI_NO_C3;
         end else begin
            id_a_c = dqt_pkg::TRI_NO_C1;
            id_b_c = dqt_pkg::TRI_NO_C2;
         end
      end else if (nz_cnt == 3'd3) begin
         cls_ok = 1'b1;
         // exactly one corner is zero; leave it out
         for (int i = 0; i < 4; i++) begin
            if (!nz[i]) begin
               id_a_c = 2'(i);
            end
         end
      end
   end

   // edge compare and queue push
   always_comb begin
      for (int e = 0; e < NE; e++) begin
         edge_ok[e] = {s2_diff_ff[e], {DW{1'b0}}} < s2_prod_ff[e];
      end
      pass_a = edge_ok[dqt_pkg::TRI_EDGE[s2_id_a_ff][0]]
             & edge_ok[dqt_pkg::TRI_EDGE[s2_id_a_ff][1]]
             & edge_ok[dqt_pkg::TRI_EDGE[s2_id_a_ff][2]];
      pass_b = s2_two_ff
             & edge_ok[dqt_pkg::TRI_EDGE[s2_id_b_ff][0]]
             & edge_ok[dqt_pkg::TRI_EDGE[s2_id_b_ff][1]]
             & edge_ok[dqt_pkg::TRI_EDGE[s2_id_b_ff][2]];
      push_need = s2_valid_ff & (pass_a | pass_b);

      q_data.d  = s2_quad_ff;
      q_data.x0 = s2_x0_ff;
      q_data.y0 = s2_y0_ff;
      if (pass_a) begin
         q_data.id_a = s2_id_a_ff;
         q_data.id_b = s2_id_b_ff;
         q_data.two  = pass_b;
      end else begin
         q_data.id_a = s2_id_b_ff;
         q_data.id_b = s2_id_b_ff;
         q_data.two  = 1'b0;
      end
   end

   assign q_push    = push_need & ~q_full;
   assign s2_free   = ~s2_valid_ff | ~push_need | ~q_full;
   assign s1_free   = ~s1_valid_ff | s2_free;
   assign req_ready = ~reset & s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         ul_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            left_ff <= req_depth;
            ul_ff   <= above;
         end
         if (s1_free) begin
            s1_valid_ff <= accept & has_quad;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff & cls_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_quad_ff <= {req_depth, left_ff, above, ul_ff};
         s1_x0_ff   <= col_ext[XW-1:0] - 1'b1;
         s1_y0_ff   <= row_ext[XW-1:0] - 1'b1;
      end
      if (s2_free & s1_valid_ff) begin
         s2_quad_ff <= s1_quad_ff;
         s2_x0_ff   <= s1_x0_ff;
         s2_y0_ff   <= s1_y0_ff;
         s2_id_a_ff <= id_a_c;
         s2_id_b_ff <= id_b_c;
         s2_two_ff  <= two_c;
         s2_diff_ff <= diff_c;
         s2_prod_ff <= prod_c;
      end
   end

endmodule

[sv/dqt_queue.sv]
// ----------------------------------------------------------------------------
// dqt_queue
// Small job queue between the pixel front end and the triangle emitter.
// ----------------------------------------------------------------------------
module dqt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dqt_pkg::tri_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output dqt_pkg::tri_job_type head
);

   localparam int QD = dqt_pkg::QUEUE_DEPTH;
   localparam int QW = $clog2(QD);

   dqt_pkg::tri_job_type entry_ff [QD];
   logic [QW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]          count_ff, count_in;

   assign full      = count_ff == (QW+1)'(QD);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/dqt_back.sv]
// ----------------------------------------------------------------------------
// dqt_back
// Triangle emitter: takes jobs from the queue and sends one triangle per
// transfer through a registered result stage.
// ----------------------------------------------------------------------------
module dqt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  dqt_pkg::tri_job_type          q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dqt_pkg::COORD_W-1:0]   rsp_ax,
   output logic [dqt_pkg::COORD_W-1:0]   rsp_ay,
   output logic [dqt_pkg::DEPTH_W-1:0]   rsp_adepth,
   output logic [dqt_pkg::COORD_W-1:0]   rsp_bx,
   output logic [dqt_pkg::COORD_W-1:0]   rsp_by_row,
   output logic [dqt_pkg::DEPTH_W-1:0]   rsp_bdepth,
   output logic [dqt_pkg::COORD_W-1:0]   rsp_cx,
   output logic [dqt_pkg::COORD_W-1:0]   rsp_cy,
   output logic [dqt_pkg::DEPTH_W-1:0]   rsp_cdepth,
   output logic                          rsp_last_of_run
);

   localparam int XW = dqt_pkg::COORD_W;
   localparam int DW = dqt_pkg::DEPTH_W;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             phase_ff, phase_in;
   logic             load, last;
   logic [1:0]       tri_id;
   logic [2:0][XW-1:0] vx, vy;
   logic [2:0][DW-1:0] vd;
   logic [2:0][XW-1:0] vx_ff, vy_ff;
   logic [2:0][DW-1:0] vd_ff;
   logic             last_ff;

   assign load   = q_not_empty & (~rsp_valid_ff | rsp_ready);
   assign tri_id = phase_ff ? q_head.id_b : q_head.id_a;
   assign last   = phase_ff | ~q_head.two;
   assign q_pop  = load & last;

   always_comb begin
      logic [1:0] c;
      for (int j = 0; j < 3; j++) begin
         c     = dqt_pkg::TRI_CORNER[tri_id][j];
         vx[j] = q_head.x0 + XW'(c[0]);
         vy[j] = q_head.y0 + XW'(c[1]);
         vd[j] = q_head.d[c];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (load) begin
         phase_in     = ~last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vx_ff   <= vx;
         vy_ff   <= vy;
         vd_ff   <= vd;
         last_ff <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ax          = vx_ff[0];
   assign rsp_ay          = vy_ff[0];
   assign rsp_adepth      = vd_ff[0];
   assign rsp_bx          = vx_ff[1];
   assign rsp_by_row      = vy_ff[1];
   assign rsp_bdepth      = vd_ff[1];
   assign rsp_cx          = vx_ff[2];
   assign rsp_cy          = vy_ff[2];
   assign rsp_cdepth      = vd_ff[2];
   assign rsp_last_of_run = last_ff;

endmodule

[sv/depth_quad_triangulator.sv]
// ----------------------------------------------------------------------------
// depth_quad_triangulator
// Depth image to triangle stream: 2x2 quads, diagonal split, edge ratio test.
// ----------------------------------------------------------------------------
// Depth pixels arrive in raster order, one per req transfer, and the block
// takes one pixel every cycle while the result side keeps up. Each triangle
// is one rsp transfer, so a quad split into two triangles takes two
// transfers through the single result register. A triangle passes the two
// front stages, the write into the 4-entry job queue and the result
// register before it shows on rsp_valid. The previous row sits in one
// MAX_WIDTH x 16 RAM that is not cleared at reset: the first row of a frame
// never uses what it reads from it. The user must write registers through
// csr_wr_en, csr_index and csr_wdata only while the block is idle; the block
// itself does not enforce it. Width and height are clamped to
// [2, MAX_WIDTH] and [2, MAX_HEIGHT].
// ----------------------------------------------------------------------------
module depth_quad_triangulator #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [dqt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dqt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dqt_pkg::DEPTH_W-1:0]       req_depth,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dqt_pkg::COORD_W-1:0]       rsp_ax,
   output logic [dqt_pkg::COORD_W-1:0]       rsp_ay,
   output logic [dqt_pkg::DEPTH_W-1:0]       rsp_adepth,
   output logic [dqt_pkg::COORD_W-1:0]       rsp_bx,
   output logic [dqt_pkg::COORD_W-1:0]       rsp_by_row,
   output logic [dqt_pkg::DEPTH_W-1:0]       rsp_bdepth,
   output logic [dqt_pkg::COORD_W-1:0]       rsp_cx,
   output logic [dqt_pkg::COORD_W-1:0]       rsp_cy,
   output logic [dqt_pkg::DEPTH_W-1:0]       rsp_cdepth,
   output logic                              rsp_last_of_run
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // last index of a clamped dimension
   function automatic int unsigned dim_last(input logic [dqt_pkg::CSR_DIM_W-1:0] v,
                                            input int unsigned hi);
      int unsigned t;
      t = 32'(v);
      if (t < 2) begin
         t = 2;
      end
      if (t > hi) begin
         t = hi;
      end
      return t - 1;
   endfunction

   logic [CW-1:0]                   col_last_ff;
   logic [RW-1:0]                   row_last_ff;
   logic [dqt_pkg::CSR_DATA_W-1:0]  max_ratio_ff;

   logic                 q_full, q_push, q_pop, q_not_empty;
   dqt_pkg::tri_job_type q_data, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff  <= CW'(dim_last(dqt_pkg::CSR_DIM_RESET, MAX_WIDTH));
         row_last_ff  <= RW'(dim_last(dqt_pkg::CSR_DIM_RESET, MAX_HEIGHT));
         max_ratio_ff <= dqt_pkg::CSR_RATIO_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dqt_pkg::CSR_IMAGE_WIDTH: begin
               col_last_ff <= CW'(dim_last(csr_wdata[dqt_pkg::CSR_DIM_W-1:0], MAX_WIDTH));
            end
            dqt_pkg::CSR_IMAGE_HEIGHT: begin
               row_last_ff <= RW'(dim_last(csr_wdata[dqt_pkg::CSR_DIM_W-1:0], MAX_HEIGHT));
            end
            dqt_pkg::CSR_MAX_RATIO: begin
               max_ratio_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   dqt_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_depth (req_depth),
      .col_last  (col_last_ff),
      .row_last  (row_last_ff),
      .max_ratio (max_ratio_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   dqt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   dqt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ax          (rsp_ax),
      .rsp_ay          (rsp_ay),
      .rsp_adepth      (rsp_adepth),
      .rsp_bx          (rsp_bx),
      .rsp_by_row      (rsp_by_row),
      .rsp_bdepth      (rsp_bdepth),
      .rsp_cx          (rsp_cx),
      .rsp_cy          (rsp_cy),
      .rsp_cdepth      (rsp_cdepth),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
